// ----- rtl/core/coolant_pump_supervisor_fsm_unit_macros.svh -----
// Assertion macros for the coolant pump supervisor.
`ifndef COOLANT_PUMP_SUPERVISOR_FSM_UNIT_MACROS_SVH
`define COOLANT_PUMP_SUPERVISOR_FSM_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("supervisor check failed");

// Next-cycle implication, checked out of reset.
`define CPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("supervisor check failed");

`endif

// ----- rtl/core/cps_pkg.sv -----
// Shared types and constants of the coolant pump supervisor.
package cps_pkg;

   localparam int TIMER_WIDTH     = 32;
   localparam int CFG_WIDTH       = 32;
   localparam int CMP_WIDTH       = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
   localparam int TEMP_WIDTH      = 12;
   localparam int ELAPSED_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic signed [TEMP_WIDTH-1:0] TRIP_RESET  = 12'sd1050;
   localparam logic signed [TEMP_WIDTH-1:0] CLEAR_RESET = 12'sd950;
   localparam logic [CFG_WIDTH-1:0]         PRIME_RESET = 32'd3000;
   localparam logic [CFG_WIDTH-1:0]         PURGE_RESET = 32'd10000;

   typedef enum logic [2:0] {
      ST_INIT     = 3'd0,
      ST_IDLE     = 3'd1,
      ST_STARTING = 3'd2,
      ST_RUNNING  = 3'd3,
      ST_FAULT    = 3'd4,
      ST_SHUTDOWN = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      FLT_NONE     = 2'd0,
      FLT_SENSOR   = 2'd1,
      FLT_LOW      = 2'd2,
      FLT_OVERTEMP = 2'd3
   } fault_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_OVERTEMP_TRIP  = 3'd0,
      REG_OVERTEMP_CLEAR = 3'd1,
      REG_PRIME_TIME     = 3'd2,
      REG_PURGE_TIME     = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [ELAPSED_WIDTH-1:0]     elapsed_ms;
      logic                         sensor_ok;
      logic                         coolant_low;
      logic                         key_on;
      logic signed [TEMP_WIDTH-1:0] coolant_temp;
   } req_item_type;

   typedef struct packed {
      mode_type  current_state;
      fault_type fault_code;
      logic      pump_on;
      logic      loop_enable;
      logic      full_cooling;
   } rsp_item_type;

endpackage

// ----- rtl/core/cps_req_if.sv -----
// Tick channel into the supervisor: handshake and one tick's fields.
interface cps_req_if
   import cps_pkg::*;
   ;
   logic                         valid;
   logic                         ready;
   logic [ELAPSED_WIDTH-1:0]     elapsed_ms;
   logic                         sensor_ok;
   logic                         coolant_low;
   logic                         key_on;
   logic signed [TEMP_WIDTH-1:0] coolant_temp;

   modport source (
      output valid, elapsed_ms, sensor_ok, coolant_low, key_on, coolant_temp,
      input  ready
   );
   modport sink (
      input  valid, elapsed_ms, sensor_ok, coolant_low, key_on, coolant_temp,
      output ready
   );
endinterface

// ----- rtl/core/cps_rsp_if.sv -----
// Command channel out of the supervisor: handshake and one result's fields.
interface cps_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] current_state;
   logic [1:0] fault_code;
   logic       pump_on;
   logic       loop_enable;
   logic       full_cooling;

   modport source (
      output valid, current_state, fault_code, pump_on, loop_enable, full_cooling,
      input  ready
   );
   modport sink (
      input  valid, current_state, fault_code, pump_on, loop_enable, full_cooling,
      output ready
   );
endinterface

// ----- rtl/core/coolant_pump_supervisor_fsm_unit.sv -----
// Coolant pump supervisor: one control tick in, one set of pump commands out.
// Throughput is one item per clock while the result register is not stalled; an accepted
// item passes through the input register, then the result register. The state, time-in-state counter
// and overtemperature latch update in the same cycle the item leaves the input
// register, so the rate is set by that loop: a timer add with saturation,
// the threshold compares and the next-state select. With the result register stalled
// one more item is taken into the input register before ready drops. Configuration
// writes take effect on the next tick and are meant to happen while the block is idle.
`include "coolant_pump_supervisor_fsm_unit_macros.svh"

module coolant_pump_supervisor_fsm_unit
   import cps_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   cps_req_if.sink                    req_chan,
   cps_rsp_if.source                  rsp_chan,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_wdata
);

   // configuration
   logic signed [TEMP_WIDTH-1:0] trip_ff;
   logic signed [TEMP_WIDTH-1:0] clear_ff;
   logic [CFG_WIDTH-1:0]         prime_ff;
   logic [CFG_WIDTH-1:0]         purge_ff;

   // pipeline
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type out_item_in;
   logic         advance;

   // supervisor state
   mode_type               mode_ff, mode_in;
   logic [TIMER_WIDTH-1:0] time_ff, time_in;
   logic                   latch_ff, latch_in;

   logic [TIMER_WIDTH:0]   time_sum;
   logic [TIMER_WIDTH-1:0] time_sat;
   logic                   latch_eval;
   fault_type              fault;
   logic                   prime_done;
   logic                   purge_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         trip_ff  <= TRIP_RESET;
         clear_ff <= CLEAR_RESET;
         prime_ff <= PRIME_RESET;
         purge_ff <= PURGE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_OVERTEMP_TRIP:  trip_ff  <= csr_wdata[TEMP_WIDTH-1:0];
            REG_OVERTEMP_CLEAR: clear_ff <= csr_wdata[TEMP_WIDTH-1:0];
            REG_PRIME_TIME:     prime_ff <= csr_wdata;
            REG_PURGE_TIME:     purge_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_item_ff.elapsed_ms   <= req_chan.elapsed_ms;
         in_item_ff.sensor_ok    <= req_chan.sensor_ok;
         in_item_ff.coolant_low  <= req_chan.coolant_low;
         in_item_ff.key_on       <= req_chan.key_on;
         in_item_ff.coolant_temp <= req_chan.coolant_temp;
      end
   end

   // saturating time in state
   always_comb begin
      time_sum = {1'b0, time_ff}
               + {{(TIMER_WIDTH + 1 - ELAPSED_WIDTH){1'b0}}, in_item_ff.elapsed_ms};
      time_sat = time_sum[TIMER_WIDTH] ? {TIMER_WIDTH{1'b1}} : time_sum[TIMER_WIDTH-1:0];
      prime_done = CMP_WIDTH'(time_sat) >= CMP_WIDTH'(prime_ff);
      purge_done = CMP_WIDTH'(time_sat) >= CMP_WIDTH'(purge_ff);
   end

   // fault priority and overtemperature hysteresis
   always_comb begin
      priority if (in_item_ff.coolant_temp >= trip_ff) begin
         latch_eval = 1'b1;
      end else if (in_item_ff.coolant_temp <= clear_ff) begin
         latch_eval = 1'b0;
      end else begin
         latch_eval = latch_ff;
      end

      latch_in = latch_ff;
      priority if (!in_item_ff.sensor_ok) begin
         fault = FLT_SENSOR;
      end else if (in_item_ff.coolant_low) begin
         fault = FLT_LOW;
      end else begin
         latch_in = latch_eval;
         fault    = latch_eval ? FLT_OVERTEMP : FLT_NONE;
      end
      // drop the latch while idle, after the faults are taken
      if (mode_ff == ST_IDLE) begin
         latch_in = 1'b0;
      end
   end

   // next state
   always_comb begin
      mode_in = mode_ff;
      unique case (mode_ff)
         ST_IDLE: begin
            if (in_item_ff.key_on) mode_in = ST_STARTING;
         end
         ST_STARTING: begin
            priority if (!in_item_ff.key_on) mode_in = ST_SHUTDOWN;
            else if (fault != FLT_NONE)      mode_in = ST_FAULT;
            else if (prime_done)             mode_in = ST_RUNNING;
            else                             mode_in = ST_STARTING;
         end
         ST_RUNNING: begin
            priority if (!in_item_ff.key_on) mode_in = ST_SHUTDOWN;
            else if (fault != FLT_NONE)      mode_in = ST_FAULT;
            else                             mode_in = ST_RUNNING;
         end
         ST_FAULT: begin
            priority if (!in_item_ff.key_on) mode_in = ST_SHUTDOWN;
            else if (fault == FLT_NONE)      mode_in = ST_STARTING;
            else                             mode_in = ST_FAULT;
         end
         ST_SHUTDOWN: begin
            priority if (in_item_ff.key_on) mode_in = ST_STARTING;
            else if (purge_done)            mode_in = ST_IDLE;
            else                            mode_in = ST_SHUTDOWN;
         end
         default: mode_in = ST_IDLE;
      endcase
      time_in = (mode_in != mode_ff) ? '0 : time_sat;
   end

   // commands from the new state
   always_comb begin
      out_item_in.current_state = mode_in;
      out_item_in.fault_code    = FLT_NONE;
      out_item_in.pump_on       = 1'b0;
      out_item_in.loop_enable   = 1'b0;
      out_item_in.full_cooling  = 1'b0;
      unique case (mode_in)
         ST_STARTING: out_item_in.pump_on = 1'b1;
         ST_RUNNING: begin
            out_item_in.pump_on     = 1'b1;
            out_item_in.loop_enable = 1'b1;
         end
         ST_FAULT: begin
            out_item_in.pump_on      = 1'b1;
            out_item_in.full_cooling = 1'b1;
            out_item_in.fault_code   = fault;
         end
         ST_SHUTDOWN: out_item_in.pump_on = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ST_INIT;
         time_ff  <= '0;
         latch_ff <= 1'b0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         time_ff  <= time_in;
         latch_ff <= latch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.current_state = out_item_ff.current_state;
   assign rsp_chan.fault_code    = out_item_ff.fault_code;
   assign rsp_chan.pump_on       = out_item_ff.pump_on;
   assign rsp_chan.loop_enable   = out_item_ff.loop_enable;
   assign rsp_chan.full_cooling  = out_item_ff.full_cooling;

   `CPS_ASSERT_NEXT(a_change_clears_timer, clock, reset, advance && (mode_in != mode_ff), time_ff == '0)
   `CPS_ASSERT_NEXT(a_idle_drops_latch, clock, reset, advance && (mode_ff == ST_IDLE), !latch_ff)
   `CPS_ASSERT_NOW(a_fault_only_in_fault, clock, reset, rsp_chan.valid && (rsp_chan.fault_code != FLT_NONE), rsp_chan.current_state == ST_FAULT)

endmodule
